@@ rtl/core/vsp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Version string parser package
// Types, character codes and helper functions shared by the parser modules.
// ----------------------------------------------------------------------------
package vsp_pkg;

	typedef enum logic [3:0] {
		PH_MAJ  = 4'd0,
		PH_MIN  = 4'd1,
		PH_INC  = 4'd2,
		PH_WSA  = 4'd3,
		PH_SV   = 4'd4,
		PH_SN   = 4'd5,
		PH_WSB  = 4'd6,
		PH_DVS  = 4'd7,
		PH_DEV  = 4'd8,
		PH_STOP = 4'd9
	} phase_t;

	typedef enum logic [2:0] {
		KIND_REL   = 3'd0,
		KIND_SVN   = 3'd1,
		KIND_DEVL  = 3'd2,
		KIND_ALPHA = 3'd3,
		KIND_BETA  = 3'd4
	} kind_t;

	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_B     = 8'h62;
	localparam logic [7:0] CH_A     = 8'h61;
	localparam logic [7:0] CH_D     = 8'h64;
	localparam logic [7:0] CH_S     = 8'h73;
	localparam logic [7:0] CH_V     = 8'h76;
	localparam logic [7:0] CH_N     = 8'h6E;
	localparam logic [7:0] CH_R     = 8'h72;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef struct packed {
		phase_t      phase;
		logic [15:0] major;
		logic [15:0] minor;
		logic [7:0]  incr;
		kind_t       kind;
		logic [31:0] dev;
		logic        dev_seen;
	} parse_state_t;

	localparam parse_state_t STATE_RESET = '{
		phase:    PH_MAJ,
		major:    16'd0,
		minor:    16'd0,
		incr:     8'd0,
		kind:     KIND_REL,
		dev:      32'd0,
		dev_seen: 1'b0
	};

	function automatic logic is_dig(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_ws(input logic [7:0] c);
		return ((c >= 8'h09) && (c <= 8'h0D)) || (c == CH_SPACE);
	endfunction

	function automatic logic [7:0] low_case(input logic [7:0] c);
		return ((c >= 8'h41) && (c <= 8'h5A)) ? (c | 8'h20) : c;
	endfunction

endpackage

@@ rtl/core/vsp_step.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Version string parser step
// Next-state logic for one byte, and the development number that the string
// reports if it ends with this byte.
// ----------------------------------------------------------------------------
module vsp_step (
	input  vsp_pkg::parse_state_t cur,
	input  logic [7:0]            char_byte,
	input  logic                  empty_end,
	output vsp_pkg::parse_state_t nxt,
	output logic [31:0]           dev_num
);
	import vsp_pkg::*;

	logic       dig;
	logic       ws;
	logic [7:0] low;
	logic       go_wsa;
	logic       go_wsb;
	logic       go_dvs;
	logic       go_dev;

	assign dig = is_dig(char_byte);
	assign ws  = is_ws(char_byte);
	assign low = low_case(char_byte);

	always_comb begin
		nxt    = cur;
		go_wsa = 1'b0;
		go_wsb = 1'b0;
		go_dvs = 1'b0;
		go_dev = 1'b0;
		if (!empty_end) begin
			case (cur.phase)
				PH_MAJ: begin
					if (dig) begin
						nxt.major = (cur.major << 3) + (cur.major << 1)
							+ {12'd0, char_byte[3:0]};
					end else begin
						nxt.phase = (char_byte == CH_DOT) ? PH_MIN : PH_STOP;
					end
				end
				PH_MIN: begin
					if (dig) begin
						nxt.minor = (cur.minor << 3) + (cur.minor << 1)
							+ {12'd0, char_byte[3:0]};
					end else if (char_byte == CH_DOT) begin
						nxt.phase = PH_INC;
					end else begin
						go_wsa = 1'b1;
					end
				end
				PH_INC: begin
					if (dig) begin
						nxt.incr = (cur.incr << 3) + (cur.incr << 1)
							+ {4'd0, char_byte[3:0]};
					end else begin
						go_wsa = 1'b1;
					end
				end
				PH_WSA: begin
					go_wsa = 1'b1;
				end
				PH_SV: begin
					if (char_byte == CH_V) begin
						nxt.phase = PH_SN;
					end else begin
						go_wsb = 1'b1;
					end
				end
				PH_SN: begin
					if (char_byte == CH_N) begin
						nxt.phase = PH_WSB;
					end else begin
						go_wsb = 1'b1;
					end
				end
				PH_WSB: begin
					go_wsb = 1'b1;
				end
				PH_DVS: begin
					go_dvs = 1'b1;
				end
				PH_DEV: begin
					go_dev = 1'b1;
				end
				default: begin
				end
			endcase

			if (go_wsa) begin
				if (ws) begin
					nxt.phase = PH_WSA;
				end else begin
					case (low)
						CH_B: nxt.kind = KIND_BETA;
						CH_A: nxt.kind = KIND_ALPHA;
						CH_D: nxt.kind = KIND_DEVL;
						CH_S: nxt.kind = KIND_SVN;
						default: nxt.kind = cur.kind;
					endcase
					nxt.phase = (low == CH_S) ? PH_SV : PH_WSB;
				end
			end

			if (go_wsb) begin
				if (ws) begin
					nxt.phase = PH_WSB;
				end else if ((cur.kind == KIND_SVN) && (low == CH_R)) begin
					nxt.phase = PH_DVS;
				end else begin
					go_dvs = 1'b1;
				end
			end

			if (go_dvs) begin
				nxt.dev_seen = 1'b1;
				go_dev = 1'b1;
			end

			if (go_dev) begin
				if (dig) begin
					nxt.dev = (cur.dev << 3) + (cur.dev << 1) + {28'd0, char_byte[3:0]};
					nxt.phase = PH_DEV;
				end else begin
					nxt.phase = PH_STOP;
				end
			end
		end
	end

	always_comb begin
		if (nxt.dev_seen) begin
			dev_num = nxt.dev;
		end else if ((nxt.phase inside {[PH_SV:PH_DVS]})
				&& (nxt.kind != KIND_REL) && (nxt.kind != KIND_SVN)) begin
			dev_num = 32'd1;
		end else begin
			dev_num = 32'd0;
		end
	end

endmodule

@@ rtl/core/version_string_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Version string parser
// Parses a version string delivered one byte per request into major, minor,
// incremental, release kind and development number.
// ----------------------------------------------------------------------------
// The block takes one byte request in every cycle unless in_stall is set. Each
// request is captured in an input register; the parse state is then updated
// from it by a single step of logic, whose longest path is one multiply-by-ten
// accumulate on the 32-bit development number. A request that ends a string
// (last_char or empty_end) then loads the result register from the input
// register once the result register is free, and the parse state returns to
// its reset value for the next string. While a result waits on out_stall,
// bytes that do not end a string keep flowing; only a second string end waits for the result register to empty.
module version_string_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  char_byte,
	input  logic        last_char,
	input  logic        empty_end,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] major_num,
	output logic [15:0] minor_num,
	output logic [7:0]  incremental_num,
	output logic [2:0]  release_kind,
	output logic [31:0] development_num
);
	import vsp_pkg::*;

	logic         s1_valid_q;
	logic [7:0]   char_s1;
	logic         last_s1;
	logic         empty_s1;
	logic         s1_end;
	logic         out_free;
	logic         s1_go;
	parse_state_t st_q;
	parse_state_t st_nxt;
	logic [31:0]  dev_nxt;
	logic         out_valid_q;
	logic [15:0]  major_q;
	logic [15:0]  minor_q;
	logic [7:0]   incr_q;
	logic [2:0]   kind_q;
	logic [31:0]  dev_q;

	assign s1_end   = last_s1 | empty_s1;
	assign out_free = !out_valid_q || !out_stall;
	assign s1_go    = s1_valid_q && (!s1_end || out_free);
	assign in_stall = s1_valid_q && !s1_go;

	vsp_step u_step (
		.cur       (st_q),
		.char_byte (char_s1),
		.empty_end (empty_s1),
		.nxt       (st_nxt),
		.dev_num   (dev_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (!in_stall) begin
			s1_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			char_s1  <= char_byte;
			last_s1  <= last_char;
			empty_s1 <= empty_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= STATE_RESET;
		end else if (s1_go) begin
			st_q <= s1_end ? STATE_RESET : st_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && s1_end) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && s1_end) begin
			major_q <= st_nxt.major;
			minor_q <= st_nxt.minor;
			incr_q  <= st_nxt.incr;
			kind_q  <= st_nxt.kind;
			dev_q   <= dev_nxt;
		end
	end

	assign out_valid       = out_valid_q;
	assign major_num       = major_q;
	assign minor_num       = minor_q;
	assign incremental_num = incr_q;
	assign release_kind    = kind_q;
	assign development_num = dev_q;

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> s1_valid_q)
		else $error("Input stalled with an empty input register.");

	a_end_resets_state: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && s1_end) |=> (st_q.phase == PH_MAJ) && !st_q.dev_seen
			&& (st_q.kind == KIND_REL))
		else $error("Parse state not cleared after a string end.");

	a_stop_holds: assert property (@(posedge clk) disable iff (!arst_n)
		((st_q.phase == PH_STOP) && !(s1_go && s1_end)) |=> (st_q.phase == PH_STOP))
		else $error("Parser left the stop phase before the string ended.");

	a_end_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && s1_end && out_valid_q && out_stall) |=> s1_valid_q)
		else $error("String end consumed while the result register was full.");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_go && s1_end) |=> out_valid_q)
		else $error("String end did not produce a result.");

endmodule

@@ dv/tb_version_string_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Version string parser testbench
// Streams version strings into the parser one byte per request and compares
// every parsed result, field by field, with a predictor inside a scoreboard.
// A few directed strings cover empty strings, default development numbers,
// unknown release letters and high bytes. Random strings follow, mostly
// well formed with random content, under three idling profiles.
// ----------------------------------------------------------------------------
module tb_version_string_parser;
	import vsp_pkg::*;

	typedef logic [7:0] byte_q[$];

	typedef struct {
		logic [15:0] major;
		logic [15:0] minor;
		logic [7:0]  incr;
		kind_t       kind;
		logic [31:0] dev;
	} version_t;

	class version_scoreboard;
		phase_t      ph;
		logic [15:0] maj;
		logic [15:0] mnr;
		logic [7:0]  inc;
		kind_t       kind;
		logic [31:0] dev;
		bit          dev_hit;
		version_t    expected_versions[$];
		int          strings;
		int          results;
		int          errors;

		function new();
			clear();
		endfunction

		function void clear();
			ph = PH_MAJ;
			maj = '0;
			mnr = '0;
			inc = '0;
			kind = KIND_REL;
			dev = '0;
			dev_hit = 1'b0;
		endfunction

		function bit digit_char(logic [7:0] c);
			return c >= 8'h30 && c <= 8'h39;
		endfunction

		function bit blank_char(logic [7:0] c);
			return (c >= 8'h09 && c <= 8'h0D) || c == CH_SPACE;
		endfunction

		function logic [7:0] fold_case(logic [7:0] c);
			return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
		endfunction

		// One byte may pass through several phases before it is consumed.
		function void consume(logic [7:0] c);
			bit          done;
			logic [7:0]  l;
			done = 1'b0;
			while (!done) begin
				done = 1'b1;
				l = fold_case(c);
				case (ph)
					PH_MAJ: begin
						if (digit_char(c))
							maj = 16'(maj * 10 + (c - 8'h30));
						else if (c == CH_DOT)
							ph = PH_MIN;
						else
							ph = PH_STOP;
					end
					PH_MIN: begin
						if (digit_char(c))
							mnr = 16'(mnr * 10 + (c - 8'h30));
						else if (c == CH_DOT)
							ph = PH_INC;
						else begin
							ph = PH_WSA;
							done = 1'b0;
						end
					end
					PH_INC: begin
						if (digit_char(c))
							inc = 8'(inc * 10 + (c - 8'h30));
						else begin
							ph = PH_WSA;
							done = 1'b0;
						end
					end
					PH_WSA: begin
						if (!blank_char(c)) begin
							if (l == CH_B)
								kind = KIND_BETA;
							else if (l == CH_A)
								kind = KIND_ALPHA;
							else if (l == CH_D)
								kind = KIND_DEVL;
							else if (l == CH_S)
								kind = KIND_SVN;
							if (l == CH_S)
								ph = PH_SV;
							else
								ph = PH_WSB;
						end
					end
					PH_SV: begin
						if (c == CH_V)
							ph = PH_SN;
						else begin
							ph = PH_WSB;
							done = 1'b0;
						end
					end
					PH_SN: begin
						ph = PH_WSB;
						if (c != CH_N)
							done = 1'b0;
					end
					PH_WSB: begin
						if (!blank_char(c)) begin
							ph = PH_DVS;
							if (!(kind == KIND_SVN && l == CH_R))
								done = 1'b0;
						end
					end
					PH_DVS: begin
						dev_hit = 1'b1;
						ph = PH_DEV;
						done = 1'b0;
					end
					PH_DEV: begin
						if (digit_char(c))
							dev = 32'(dev * 10 + (c - 8'h30));
						else
							ph = PH_STOP;
					end
					default: ;
				endcase
			end
		endfunction

		function void note_request(logic [7:0] c, logic last, logic empty);
			version_t v;
			if (!empty)
				consume(c);
			if (last || empty) begin
				v.major = maj;
				v.minor = mnr;
				v.incr = inc;
				v.kind = kind;
				if (dev_hit)
					v.dev = dev;
				else if (ph >= PH_SV && ph <= PH_DVS &&
						(kind == KIND_DEVL || kind == KIND_ALPHA || kind == KIND_BETA))
					v.dev = 32'd1;
				else
					v.dev = 32'd0;
				expected_versions.push_back(v);
				strings++;
				clear();
			end
		endfunction

		function void check_result(logic [15:0] major, logic [15:0] minor, logic [7:0] incr,
				logic [2:0] kind_bits, logic [31:0] dev_val);
			version_t want;
			if (expected_versions.size() == 0) begin
				$error("Result arrived with no string pending.");
				errors++;
				return;
			end
			want = expected_versions.pop_front();
			results++;
			if (major !== want.major) begin
				$error("major_num: expected %0d, got %0d", want.major, major);
				errors++;
			end
			if (minor !== want.minor) begin
				$error("minor_num: expected %0d, got %0d", want.minor, minor);
				errors++;
			end
			if (incr !== want.incr) begin
				$error("incremental_num: expected %0d, got %0d", want.incr, incr);
				errors++;
			end
			if (kind_bits !== 3'(want.kind)) begin
				$error("release_kind: expected %0d, got %0d", want.kind, kind_bits);
				errors++;
			end
			if (dev_val !== want.dev) begin
				$error("development_num: expected %0d, got %0d", want.dev, dev_val);
				errors++;
			end
		endfunction

		function int pending();
			return expected_versions.size();
		endfunction
	endclass

	localparam int RANDOM_REQUESTS = 1850;
	localparam int IDLE_LIMIT = 2000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  char_byte;
	logic        last_char;
	logic        empty_end;
	logic        out_valid;
	logic        out_stall;
	logic [15:0] major_num;
	logic [15:0] minor_num;
	logic [7:0]  incremental_num;
	logic [2:0]  release_kind;
	logic [31:0] development_num;

	version_scoreboard sb = new();
	int sent;
	int send_idle_pct;
	int recv_stall_pct;
	int idle_cycles;

	version_string_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.char_byte(char_byte),
		.last_char(last_char),
		.empty_end(empty_end),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.major_num(major_num),
		.minor_num(minor_num),
		.incremental_num(incremental_num),
		.release_kind(release_kind),
		.development_num(development_num)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(major_num, minor_num, incremental_num, release_kind,
					development_num);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Watchdog expired with %0d results outstanding.", sb.pending());
			$display("version_string_parser: mismatch");
			$finish;
		end
	end

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_request(input logic [7:0] c, input logic l, input logic e);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		char_byte <= c;
		last_char <= l;
		empty_end <= e;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_request(c, l, e);
		sent++;
		@(negedge clk);
	endtask

	task automatic send_bytes(input byte_q s, input bit end_empty);
		bit use_empty;
		use_empty = end_empty || s.size() == 0;
		foreach (s[i])
			send_request(s[i], i == s.size() - 1 && !use_empty, 1'b0);
		if (use_empty)
			send_request(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(negedge clk);
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	function automatic byte_q from_text(string t);
		byte_q s;
		for (int i = 0; i < t.len(); i++)
			s.push_back(t[i]);
		return s;
	endfunction

	function automatic byte_q digits(int n);
		byte_q s;
		bit nines;
		nines = ($urandom_range(0, 7) == 0);
		repeat (n)
			s.push_back(8'(8'h30 + (nines ? 9 : $urandom_range(0, 9))));
		return s;
	endfunction

	function automatic byte_q blanks(int n);
		byte_q s;
		int v;
		repeat (n) begin
			v = $urandom_range(8, 13);
			s.push_back(v == 8 ? CH_SPACE : 8'(v));
		end
		return s;
	endfunction

	function automatic byte_q build_version();
		byte_q s;
		int k;
		logic [7:0] c;
		s = digits($urandom_range(0, 6));
		if ($urandom_range(0, 19) == 0)
			return s;
		s.push_back(CH_DOT);
		s = {s, digits($urandom_range(0, 6))};
		if ($urandom_range(0, 1)) begin
			s.push_back(CH_DOT);
			s = {s, digits($urandom_range(0, 4))};
		end
		s = {s, blanks($urandom_range(0, 2))};
		if ($urandom_range(0, 9) == 0)
			return s;
		k = $urandom_range(0, 9);
		if (k < 8) begin
			case (k % 4)
				0: c = CH_B;
				1: c = CH_A;
				2: c = CH_D;
				default: c = CH_S;
			endcase
			s.push_back(k >= 4 ? c - 8'h20 : c);
			if (c == CH_S) begin
				if ($urandom_range(0, 3) != 0)
					s.push_back($urandom_range(0, 4) == 0 ? CH_V - 8'h20 : CH_V);
				if ($urandom_range(0, 3) != 0)
					s.push_back($urandom_range(0, 4) == 0 ? CH_N - 8'h20 : CH_N);
			end
		end else if (k == 8)
			s.push_back(8'($urandom_range(33, 126)));
		s = {s, blanks($urandom_range(0, 2))};
		if ($urandom_range(0, 2) == 0)
			s.push_back($urandom_range(0, 1) ? CH_R : CH_R - 8'h20);
		s = {s, digits($urandom_range(0, 3) == 0 ? $urandom_range(6, 11) :
				$urandom_range(0, 5))};
		if ($urandom_range(0, 3) == 0)
			s.push_back(8'($urandom_range(0, 255)));
		return s;
	endfunction

	function automatic byte_q build_junk(bit textlike);
		byte_q s;
		string pool;
		pool = "bBaAdDsSvVnNrRx";
		repeat ($urandom_range(0, 8)) begin
			if (!textlike)
				s.push_back(8'($urandom_range(0, 255)));
			else case ($urandom_range(0, 5))
				0, 1: s.push_back(8'(8'h30 + $urandom_range(0, 9)));
				2: s.push_back(CH_DOT);
				3: s = {s, blanks(1)};
				4: s.push_back(pool[$urandom_range(0, pool.len() - 1)]);
				default: s.push_back(8'($urandom_range(128, 255)));
			endcase
		end
		return s;
	endfunction

	initial begin
		int base;
		int r;
		byte_q s;
		arst_n = 1'b0;
		in_valid = 1'b0;
		char_byte = 8'h00;
		last_char = 1'b0;
		empty_end = 1'b0;
		sent = 0;
		send_idle_pct = 24;
		recv_stall_pct = 78;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Empty string where empty_end and last_char are both set.
		send_request(8'hFF, 1'b1, 1'b1);
		send_bytes(from_text("1.2D"), 1'b0);
		send_bytes(from_text("3.4.5sr9"), 1'b0);
		s = from_text("1.1b");
		s.push_back(8'hFF);
		send_bytes(s, 1'b1);
		send_bytes(from_text("0.0x7"), 1'b0);
		drain();

		base = sent;
		for (int p = 0; p < 3; p++) begin
			send_idle_pct = (p == 0) ? 24 : (p == 1) ? 78 : 0;
			recv_stall_pct = (p == 0) ? 78 : (p == 1) ? 24 : 0;
			while (sent < base + (p + 1) * RANDOM_REQUESTS / 3) begin
				r = $urandom_range(0, 99);
				if (r < 70)
					s = build_version();
				else if (r < 85)
					s = build_junk(1'b1);
				else
					s = build_junk(1'b0);
				send_bytes(s, $urandom_range(0, 4) == 0);
			end
			drain();
		end

		repeat (10) @(posedge clk);
		$display("Sent %0d byte requests forming %0d strings; %0d results compared.",
				sent, sb.strings, sb.results);
		$display("Traffic ran sender-idle, receiver-stall and back-to-back profiles.");
		if (sb.errors == 0 && sb.pending() == 0)
			$display("version_string_parser: match");
		else
			$display("version_string_parser: mismatch");
		$finish;
	end
endmodule
